// ===== sv/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared widths, constants and register indexes of the downmix resampler.
// ----------------------------------------------------------------------------
package dlr_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int FRAME_BITS_DEF   = 16;

	localparam int SAMPLE_W   = 16;
	localparam int INDEX_W    = 20;
	localparam int RATE_W     = 18;
	localparam int STEP_W     = 21;
	localparam int OUT_RATE_W = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_W     = 16;

	// Shared divider: Q16 step needs rate<<16 as dividend, the output rate as divisor.
	localparam int DIVD_W = RATE_W + FRAC_W;
	localparam int DIVS_W = RATE_W;

	localparam int MAX_RESULTS = 32;

	localparam logic [RATE_W-1:0]     RATE_LOW      = RATE_W'(1000);
	localparam logic [RATE_W-1:0]     RATE_HIGH     = RATE_W'(192000);
	localparam logic [RATE_W-1:0]     RATE_RESET    = RATE_W'(48000);
	localparam logic [OUT_RATE_W-1:0] OUT_RATE_FAST = OUT_RATE_W'(16000);
	localparam logic [OUT_RATE_W-1:0] OUT_RATE_SLOW = OUT_RATE_W'(8000);

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd3;

endpackage

// ===== sv/dlr_div.sv =====
// ----------------------------------------------------------------------------
// dlr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlr_div #(
	parameter int N = dlr_pkg::DIVD_W,
	parameter int D = dlr_pkg::DIVS_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);
	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [D:0]       trial;
	logic [D:0]       diff;
	logic             fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(N - 1));
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
				quo_q <= {quo_q[N-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/dlr_interp.sv =====
// ----------------------------------------------------------------------------
// dlr_interp
// Linear interpolation between two mono samples with Q16 fraction, saturated.
// ----------------------------------------------------------------------------
module dlr_interp (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic signed [dlr_pkg::SAMPLE_W-1:0]  s0,
	input  logic signed [dlr_pkg::SAMPLE_W-1:0]  s1,
	input  logic        [dlr_pkg::FRAC_W-1:0]    frac,
	output logic signed [dlr_pkg::SAMPLE_W-1:0]  result
);
	import dlr_pkg::*;

	localparam int PROD_W = SAMPLE_W + FRAC_W + 2;
	localparam int SUM_W  = SAMPLE_W + 2;

	logic signed [SAMPLE_W:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [SAMPLE_W-1:0] s0_s1;
	logic signed [SUM_W-1:0]    sum;

	// s0*(1-f) + s1*f == s0 + (s1-s0)*f, floor shift keeps the rounding.
	assign diff = SAMPLE_W'(0) + {s1[SAMPLE_W-1], s1} - {s0[SAMPLE_W-1], s0};
	assign prod = PROD_W'(diff) * $signed({2'b00, frac});

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= prod;
			s0_s1   <= s0;
		end
	end

	assign sum = SUM_W'(s0_s1) + prod_s1[PROD_W-1:FRAC_W];

	always_comb begin
		if (sum > SUM_W'(SAT_MAX)) result = SAT_MAX;
		else if (sum < SUM_W'(SAT_MIN)) result = SAT_MIN;
		else result = sum[SAMPLE_W-1:0];
	end

endmodule

// ===== sv/downmix_linear_resampler_core.sv =====
// ----------------------------------------------------------------------------
// downmix_linear_resampler_core
// Downmixes interleaved samples to mono and resamples by linear interpolation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          one interleaved sample, start flag
// m_axis    out        tvalid/tready/tlast    mono sample and its output index
// cfg       in         cfg_we                 rate, mode, channels, frames
//
// A sample that only adds into the channel sum passes S_IDLE and S_ACC. A
// request with the start flag first runs two passes of the shared divider
// (step size, output count), 34 quotient bits each. A sample that completes
// a frame runs one more divider pass for the channel average, S_CHK and
// S_OUT per output result, and S_FIN to wrap up, after a second S_CHK for
// every frame but the first of a buffer. Reset is asynchronous; it loads
// the config defaults and clears the rest but the interpolator. A stalled
// output holds the sequencer only when a pending result must be handed over.
// ----------------------------------------------------------------------------
module downmix_linear_resampler_core #(
	parameter int MAX_CHANNELS = dlr_pkg::MAX_CHANNELS_DEF,
	parameter int FRAME_BITS   = dlr_pkg::FRAME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [15:0] sample
	input  logic [0:0]                        s_axis_tuser,  // [0] start_req
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [39:0]                       m_axis_tdata,  // [15:0] out_sample, [35:16] out_index
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [dlr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dlr_pkg::RATE_W-1:0]        cfg_data
);
	import dlr_pkg::*;

	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
	localparam int N_W   = $clog2(MAX_RESULTS + 1);
	localparam int CAPN_W = FRAME_BITS + OUT_RATE_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DSTEP = 8'b0000_0010,
		S_DCAP  = 8'b0000_0100,
		S_ACC   = 8'b0000_1000,
		S_DMONO = 8'b0001_0000,
		S_CHK   = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [RATE_W-1:0] input_rate_q;
	logic              rate_mode_q;
	logic [3:0]        channel_count_q;
	logic [15:0]       frame_count_q;

	// Resampler state.
	logic [31:0]                pos_q;
	logic [STEP_W-1:0]          step_q;
	logic [INDEX_W-1:0]         cap_q;
	logic [INDEX_W-1:0]         done_q;
	logic [FRAME_BITS-1:0]      seen_q;
	logic [CH_W-1:0]            chidx_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       fin_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] mono_q;
	logic                       neg_q;
	logic                       phase_q;
	logic [N_W-1:0]             n_q;
	logic                       pend_valid_q;
	logic signed [SAMPLE_W-1:0] pend_data_q;
	logic [INDEX_W-1:0]         pend_idx_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic [INDEX_W-1:0]         out_index_q;
	logic                       out_last_q;

	logic [CH_W-1:0]            ch;
	logic [FRAME_BITS-1:0]      frames;
	logic [RATE_W-1:0]          rate_cl;
	logic [OUT_RATE_W-1:0]      orate;
	logic [CAPN_W-1:0]          cap_num;
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;

	logic [CH_W-1:0]            idx_base;
	logic signed [SUM_W-1:0]    sum_base;
	logic signed [SUM_W-1:0]    sum_new;
	logic [CH_W-1:0]            idx_new;
	logic [SUM_W-1:0]           sum_mag;
	logic [SAMPLE_W-1:0]        quo16;

	logic [FRAME_BITS-1:0]      target;
	logic                       is_end;
	logic                       go;
	logic [32:0]                next_pos;
	logic signed [SAMPLE_W-1:0] s0;
	logic signed [SAMPLE_W-1:0] s1;
	logic signed [SAMPLE_W-1:0] interp_res;

	logic                       div_start;
	logic [DIVD_W-1:0]          div_dividend;
	logic [DIVS_W-1:0]          div_divisor;
	logic                       div_done;
	logic [DIVD_W-1:0]          div_quo;

	// Effective register values.
	always_comb begin
		if (channel_count_q == '0) ch = CH_W'(1);
		else if (32'(channel_count_q) > MAX_CHANNELS) ch = CH_W'(MAX_CHANNELS);
		else ch = CH_W'(channel_count_q);
	end

	assign frames = (frame_count_q[FRAME_BITS-1:0] == '0) ? FRAME_BITS'(1)
		: frame_count_q[FRAME_BITS-1:0];

	always_comb begin
		if (input_rate_q < RATE_LOW) rate_cl = RATE_LOW;
		else if (input_rate_q > RATE_HIGH) rate_cl = RATE_HIGH;
		else rate_cl = input_rate_q;
	end

	assign orate   = rate_mode_q ? OUT_RATE_SLOW : OUT_RATE_FAST;
	assign cap_num = CAPN_W'(frames) * CAPN_W'(orate);

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// The pending result moves to the output register while the sequencer
	// checks the next emission or wraps up the frame.
	assign out_load = pend_valid_q && out_free
		&& (((state_q == S_CHK) && go) || (state_q == S_FIN));

	// Channel accumulation; a stale full count means a new frame starts.
	assign idx_base = (chidx_q >= ch) ? '0 : chidx_q;
	assign sum_base = (chidx_q >= ch) ? '0 : sum_q;
	assign sum_new  = sum_base + SUM_W'(sample_q);
	assign idx_new  = idx_base + 1'b1;
	assign sum_mag  = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
	assign quo16    = div_quo[SAMPLE_W-1:0];

	// Next emission test.
	assign target   = phase_q ? seen_q : seen_q - 1'b1;
	assign is_end   = ({1'b0, seen_q} + 1'b1) == {1'b0, frames};
	assign go       = !fin_q && (done_q < cap_q) && (pos_q[31:16] == 16'(target))
		&& (n_q < N_W'(MAX_RESULTS)) && (!phase_q || is_end);
	assign next_pos = {1'b0, pos_q} + 33'(step_q);
	assign s0       = phase_q ? mono_q : prev_q;
	assign s1       = phase_q ? '0 : mono_q;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIVD_W'(sum_mag);
		div_divisor  = DIVS_W'(ch);
		unique case (state_q)
			S_IDLE: begin
				div_start    = in_acc && s_axis_tuser[0];
				div_dividend = {rate_cl, FRAC_W'(0)};
				div_divisor  = DIVS_W'(orate);
			end
			S_DSTEP: begin
				div_start    = div_done;
				div_dividend = DIVD_W'(cap_num);
				div_divisor  = rate_cl;
			end
			S_ACC: begin
				div_start = (seen_q < frames) && (idx_new >= ch);
			end
			S_DCAP, S_DMONO, S_CHK, S_OUT, S_FIN: begin
				div_start = 1'b0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dlr_div #(
		.N(DIVD_W),
		.D(DIVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	dlr_interp u_interp (
		.clk   (clk),
		.load  ((state_q == S_CHK) && go),
		.s0    (s0),
		.s1    (s1),
		.frac  (pos_q[15:0]),
		.result(interp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_rate_q    <= RATE_RESET;
			rate_mode_q     <= 1'b0;
			channel_count_q <= 4'd2;
			frame_count_q   <= 16'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_RATE:    input_rate_q    <= cfg_data;
				REG_RATE_MODE:     rate_mode_q     <= cfg_data[0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				REG_FRAME_COUNT:   frame_count_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			step_q       <= '0;
			cap_q        <= '0;
			done_q       <= '0;
			seen_q       <= '0;
			chidx_q      <= '0;
			sum_q        <= '0;
			prev_q       <= '0;
			fin_q        <= 1'b0;
			sample_q     <= '0;
			mono_q       <= '0;
			neg_q        <= 1'b0;
			phase_q      <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_data_q  <= '0;
			pend_idx_q   <= '0;
			out_sample_q <= '0;
			out_index_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sample_q <= s_axis_tdata;
						if (s_axis_tuser[0]) begin
							pos_q   <= '0;
							done_q  <= '0;
							seen_q  <= '0;
							chidx_q <= '0;
							sum_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= S_DSTEP;
						end else begin
							state_q <= S_ACC;
						end
					end
				end
				S_DSTEP: begin
					if (div_done) begin
						step_q  <= div_quo[STEP_W-1:0];
						state_q <= S_DCAP;
					end
				end
				S_DCAP: begin
					if (div_done) begin
						cap_q   <= div_quo[INDEX_W-1:0];
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (seen_q >= frames) begin
						state_q <= S_IDLE;
					end else if (idx_new < ch) begin
						sum_q   <= sum_new;
						chidx_q <= idx_new;
						state_q <= S_IDLE;
					end else begin
						neg_q   <= sum_new[SUM_W-1];
						sum_q   <= '0;
						chidx_q <= '0;
						state_q <= S_DMONO;
					end
				end
				S_DMONO: begin
					if (div_done) begin
						mono_q  <= neg_q ? -quo16 : quo16;
						phase_q <= (seen_q == '0);
						n_q     <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (go) begin
						// A result is only handed over once its successor is known.
						if (!pend_valid_q) begin
							state_q <= S_OUT;
						end else if (out_free) begin
							out_sample_q <= pend_data_q;
							out_index_q  <= pend_idx_q;
							out_last_q   <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= S_OUT;
						end
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_OUT: begin
					pend_data_q  <= interp_res;
					pend_idx_q   <= done_q;
					pend_valid_q <= 1'b1;
					n_q          <= n_q + 1'b1;
					done_q       <= done_q + 1'b1;
					pos_q        <= next_pos[31:0];
					if ((next_pos[32:16] >= 17'(frames))
							|| ((21'(done_q) + 1'b1) >= 21'(cap_q))) begin
						fin_q <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_FIN: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_sample_q <= pend_data_q;
							out_index_q  <= pend_idx_q;
							out_last_q   <= 1'b1;
							pend_valid_q <= 1'b0;
						end
						if (is_end) fin_q <= 1'b1;
						prev_q  <= mono_q;
						seen_q  <= seen_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_index_q, out_sample_q};
	assign m_axis_tlast  = out_last_q;

endmodule
